/* hdl/uniform_bin_histogram_top_assert.svh */
// Assertion macros used by the histogram datapath RTL.
`ifndef UNIFORM_BIN_HISTOGRAM_TOP_ASSERT_SVH
`define UNIFORM_BIN_HISTOGRAM_TOP_ASSERT_SVH
`ifndef SYNTH
`define UBH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UBH_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define UBH_ASSERT(label, clk, rst_n, prop, msg)
`define UBH_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

/* hdl/ubh_pkg.sv */
package ubh_pkg;

    localparam int MAX_BINS_DEF   = 1024;
    localparam int COUNT_BITS_DEF = 32;

    localparam int MODE_W      = 3;
    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 10;
    localparam int WIDTH_W     = 31;
    localparam int NBINS_W     = 11;
    localparam int OUT_W       = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 112;

    localparam logic [VALUE_W-1:0] RANGE_LOW_RST  = 32'sd0;
    localparam logic [VALUE_W-1:0] RANGE_HIGH_RST = 32'd67108864;
    localparam logic [WIDTH_W-1:0] BIN_WIDTH_RST  = 31'd65536;
    localparam logic [VALUE_W-1:0] INV_WIDTH_RST  = 32'd65536;
    localparam logic [NBINS_W-1:0] NBINS_RST      = 11'd1024;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD_VAL  = 3'd0,
        MODE_ADD_IDX  = 3'd1,
        MODE_READ_VAL = 3'd2,
        MODE_READ_IDX = 3'd3,
        MODE_TOTAL    = 3'd4,
        MODE_EDGE     = 3'd5
    } mode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RANGE_LOW  = 3'd0,
        REG_RANGE_HIGH = 3'd1,
        REG_BIN_WIDTH  = 3'd2,
        REG_INV_WIDTH  = 3'd3,
        REG_BIN_COUNT  = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_BIN,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear_en;
        logic load;
        logic mul_en;
        logic bin_en;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } ctrl_status_t;

    // Saturate a count to the 32-bit result field.
    function automatic logic [OUT_W-1:0] sat32(input logic [63:0] v);
        logic [OUT_W-1:0] r;
        begin
            r = (v > 64'h0000_0000_FFFF_FFFF) ? '1 : v[OUT_W-1:0];
            return r;
        end
    endfunction

endpackage

/* hdl/uniform_bin_histogram_top.sv */
// An accepted item is loaded in IDLE, passes MUL, BIN and READ, and waits in DONE until
// the output register is free; items do not overlap, as the multiply stage and the single
// registered read port of the count memory, then its write-back, serve one item at a time.
// Reset: rst_n clears control and loads register defaults, then a clearing pass over all
// MAX_BINS entries zeroes the count memory with s_tready low; config writes still land.
module uniform_bin_histogram_top #(
    parameter int MAX_BINS   = ubh_pkg::MAX_BINS_DEF,
    parameter int COUNT_BITS = ubh_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [ubh_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ubh_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ubh_pkg::IN_TDATA_W-1:0]    s_tdata,   // sample[31:0], bin_index[41:32]
    input  logic [ubh_pkg::MODE_W-1:0]        s_tuser,   // mode[2:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ubh_pkg::OUT_TDATA_W-1:0]   m_tdata,   // count[31:0], bin_number[41:32],
                                                         // bin_edge[73:42], total[105:74]
    output logic                              m_tuser    // in_range
);
    import ubh_pkg::*;

    ctrl_cmd_t          cmd;
    ctrl_status_t       status;
    logic [OUT_W-1:0]   res_count;
    logic [INDEX_W-1:0] res_bin;
    logic [VALUE_W-1:0] res_edge;
    logic [OUT_W-1:0]   res_total;

    ubh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ubh_datapath #(
        .MAX_BINS   (MAX_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_mode      (s_tuser),
        .in_sample    (s_tdata[31:0]),
        .in_index     (s_tdata[41:32]),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_count    (res_count),
        .out_in_range (m_tuser),
        .out_bin      (res_bin),
        .out_edge     (res_edge),
        .out_total    (res_total)
    );

    assign m_tdata = {6'd0, res_total, res_edge, res_bin, res_count};

endmodule

/* hdl/ubh_ctrl.sv */
module ubh_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  ubh_pkg::ctrl_status_t status,
    output ubh_pkg::ctrl_cmd_t    cmd
);
    import ubh_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_BIN;
            ST_BIN:  state_next = ST_READ;
            ST_READ: state_next = ST_DONE;
            ST_DONE:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.clear_en = 1'b1;
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_MUL:  cmd.mul_en = 1'b1;
            ST_BIN:  cmd.bin_en = 1'b1;
            ST_READ: cmd = '0;
            ST_DONE: cmd.finish = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

/* hdl/ubh_datapath.sv */
`include "uniform_bin_histogram_top_assert.svh"

module ubh_datapath #(
    parameter int MAX_BINS   = ubh_pkg::MAX_BINS_DEF,
    parameter int COUNT_BITS = ubh_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ubh_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [ubh_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [ubh_pkg::MODE_W-1:0]      in_mode,
    input  logic [ubh_pkg::VALUE_W-1:0]     in_sample,
    input  logic [ubh_pkg::INDEX_W-1:0]     in_index,
    input  ubh_pkg::ctrl_cmd_t              cmd,
    output ubh_pkg::ctrl_status_t           status,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [ubh_pkg::OUT_W-1:0]       out_count,
    output logic                            out_in_range,
    output logic [ubh_pkg::INDEX_W-1:0]     out_bin,
    output logic [ubh_pkg::VALUE_W-1:0]     out_edge,
    output logic [ubh_pkg::OUT_W-1:0]       out_total
);
    import ubh_pkg::*;

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int UW = ($clog2(MAX_BINS + 1) > NBINS_W) ? $clog2(MAX_BINS + 1) : NBINS_W;
    localparam int CW = COUNT_BITS;

    // configuration
    logic [VALUE_W-1:0] low_reg;
    logic [VALUE_W-1:0] high_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [VALUE_W-1:0] inv_reg;
    logic [NBINS_W-1:0] nbins_reg;
    logic [UW-1:0]      used;

    // item registers
    logic [MODE_W-1:0]  mode_reg;
    logic [VALUE_W-1:0] sample_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [63:0]        prod_reg;
    logic [40:0]        eprod_reg;
    logic               range_ok_reg;
    logic [AW-1:0]      bin_reg;
    logic               valid_reg;
    logic [VALUE_W-1:0] edge_reg;
    logic [CW-1:0]      rd_reg;

    logic [CW-1:0]      mem [MAX_BINS];
    logic [AW-1:0]      clear_addr_reg;
    logic [CW-1:0]      total_reg;

    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_count_reg;
    logic               out_in_range_reg;
    logic [INDEX_W-1:0] out_bin_reg;
    logic [VALUE_W-1:0] out_edge_reg;
    logic [OUT_W-1:0]   out_total_reg;

    logic [VALUE_W:0]   diff;
    logic [63:0]        prod;
    logic [40:0]        eprod;
    logic               range_ok;
    logic               is_val_mode;
    logic               is_idx_mode;
    logic               is_add;
    logic               bump;
    logic [31:0]        bin_raw;
    logic [31:0]        bin_sel;
    logic               valid_sel;
    logic signed [41:0] edge_sum;
    logic [VALUE_W-1:0] edge_sat;
    logic [CW-1:0]      cnt_inc;
    logic [CW-1:0]      cnt_new;
    logic [CW-1:0]      total_inc;
    logic [CW-1:0]      total_new;
    logic [OUT_W-1:0]   res_count;
    logic               res_in_range;
    logic [INDEX_W-1:0] res_bin;
    logic [VALUE_W-1:0] res_edge;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [CW-1:0]      mem_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg   <= RANGE_LOW_RST;
            high_reg  <= RANGE_HIGH_RST;
            width_reg <= BIN_WIDTH_RST;
            inv_reg   <= INV_WIDTH_RST;
            nbins_reg <= NBINS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_RANGE_LOW:  low_reg   <= cfg_wdata;
                REG_RANGE_HIGH: high_reg  <= cfg_wdata;
                REG_BIN_WIDTH:  width_reg <= cfg_wdata[WIDTH_W-1:0];
                REG_INV_WIDTH:  inv_reg   <= cfg_wdata;
                REG_BIN_COUNT:  nbins_reg <= cfg_wdata[NBINS_W-1:0];
                default:        ;
            endcase
        end
    end

    // zero bins act as one bin, too many as the table size
    always_comb
    begin
        if (nbins_reg == '0)
        begin
            used = UW'(1);
        end
        else if (UW'(nbins_reg) > UW'(MAX_BINS))
        begin
            used = UW'(MAX_BINS);
        end
        else
        begin
            used = UW'(nbins_reg);
        end
    end

    assign is_val_mode = (mode_reg == MODE_ADD_VAL) || (mode_reg == MODE_READ_VAL);
    assign is_idx_mode = (mode_reg == MODE_ADD_IDX) || (mode_reg == MODE_READ_IDX) ||
                         (mode_reg == MODE_EDGE);
    assign is_add      = (mode_reg == MODE_ADD_VAL) || (mode_reg == MODE_ADD_IDX);
    assign bump        = is_add && valid_reg;

    // multiply stage
    assign diff     = {sample_reg[VALUE_W-1], sample_reg} - {low_reg[VALUE_W-1], low_reg};
    assign prod     = diff[VALUE_W-1:0] * inv_reg;
    assign eprod    = width_reg * index_reg;
    assign range_ok = ($signed(sample_reg) > $signed(low_reg)) &&
                      ($signed(sample_reg) < $signed(high_reg));

    // bin select stage
    assign bin_raw = prod_reg[63:32];

    always_comb
    begin
        bin_sel   = '0;
        valid_sel = 1'b0;
        if (is_val_mode)
        begin
            valid_sel = range_ok_reg;
            bin_sel   = (bin_raw >= 32'(used)) ? 32'(used) - 32'd1 : bin_raw;
        end
        else if (is_idx_mode)
        begin
            valid_sel = UW'(index_reg) < used;
            bin_sel   = 32'(index_reg);
        end
    end

    assign edge_sum = 42'(signed'(low_reg)) + $signed({1'b0, eprod_reg});

    always_comb
    begin
        if (edge_sum[41:31] == '0 || edge_sum[41:31] == '1)
        begin
            edge_sat = edge_sum[31:0];
        end
        else if (edge_sum[41])
        begin
            edge_sat = 32'h8000_0000;
        end
        else
        begin
            edge_sat = 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= in_mode;
            sample_reg <= in_sample;
            index_reg  <= in_index;
        end
        if (cmd.mul_en)
        begin
            prod_reg     <= prod;
            eprod_reg    <= eprod;
            range_ok_reg <= range_ok;
        end
        if (cmd.bin_en)
        begin
            bin_reg   <= AW'(bin_sel);
            valid_reg <= valid_sel;
            edge_reg  <= edge_sat;
        end
    end

    // count table: one write port, one registered read port
    assign mem_we    = cmd.clear_en || (cmd.finish && bump);
    assign mem_waddr = cmd.clear_en ? clear_addr_reg : bin_reg;
    assign mem_wdata = cmd.clear_en ? '0 : cnt_inc;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[bin_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            clear_addr_reg <= status.clear_last ? '0 : clear_addr_reg + AW'(1);
        end
    end

    assign status.clear_last = (clear_addr_reg == AW'(MAX_BINS - 1));
    assign status.out_free   = !out_valid_reg || out_ready;

    // update and report
    assign cnt_inc   = (rd_reg == '1) ? rd_reg : rd_reg + CW'(1);
    assign cnt_new   = bump ? cnt_inc : rd_reg;
    assign total_inc = (total_reg == '1) ? total_reg : total_reg + CW'(1);
    assign total_new = bump ? total_inc : total_reg;

    always_comb
    begin
        res_count    = '0;
        res_in_range = 1'b0;
        res_bin      = '0;
        res_edge     = '0;
        case (mode_reg)
            MODE_ADD_VAL, MODE_ADD_IDX, MODE_READ_VAL, MODE_READ_IDX:
            begin
                if (valid_reg)
                begin
                    res_count    = sat32(64'(cnt_new));
                    res_in_range = 1'b1;
                    res_bin      = INDEX_W'(bin_reg);
                end
            end
            MODE_TOTAL: res_in_range = 1'b1;
            MODE_EDGE:
            begin
                res_edge     = edge_reg;
                res_in_range = valid_reg;
                res_bin      = index_reg;
            end
            default: res_in_range = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                total_reg     <= total_new;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_count_reg    <= res_count;
            out_in_range_reg <= res_in_range;
            out_bin_reg      <= res_bin;
            out_edge_reg     <= res_edge;
            out_total_reg    <= sat32(64'(total_new));
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_count    = out_count_reg;
    assign out_in_range = out_in_range_reg;
    assign out_bin      = out_bin_reg;
    assign out_edge     = out_edge_reg;
    assign out_total    = out_total_reg;

    `UBH_ASSERT_NEXT(a_clear_sweep, clk, rst_n, (rst_n && cmd.clear_en && !status.clear_last),
        (clear_addr_reg == $past(clear_addr_reg) + AW'(1)), "clear sweep skipped an entry")
    `UBH_ASSERT(a_finish_free, clk, rst_n, (cmd.finish |-> status.out_free),
        "result overwrote an item not yet taken")
    `UBH_ASSERT_NEXT(a_total_hold, clk, rst_n, !(cmd.finish && bump), $stable(total_reg),
        "total changed without a counted item")
    `UBH_ASSERT(a_bin_limit, clk, rst_n,
        ((cmd.finish && valid_reg && is_val_mode) |-> (UW'(bin_reg) < used)),
        "value bin beyond the bins in use")

endmodule

/* bench/histogram_checker.sv */
module histogram_checker
    import ubh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // sample[31:0], bin_index[41:32]
    input  logic [MODE_W-1:0]      s_tuser,   // mode[2:0]
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // count[31:0], bin_number[41:32],
                                              // bin_edge[73:42], total[105:74]
    input  logic                   m_tuser,   // in_range
    output int                     mismatches,
    output int                     outstanding
);

    localparam longint EDGE_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint EDGE_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic [31:0] count;
        logic        in_range;
        logic [9:0]  bin_number;
        logic [31:0] bin_edge;
        logic [31:0] total;
    } hist_result_t;

    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic [30:0]        width_q;
    logic [31:0]        recip_q;
    logic [10:0]        nbins_q;

    logic [31:0]  bin_tally [MAX_BINS_DEF];
    logic [31:0]  sample_total;
    hist_result_t expected_results [$];
    int           error_tally;

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic hist_result_t predict_histogram_op(input logic [2:0]  op,
                                                          input logic [31:0] raw_sample,
                                                          input logic [9:0]  idx);
        hist_result_t r;
        longint       used;
        longint       s;
        longint       edge_v;
        logic [63:0]  prod;
        logic [63:0]  bin64;
        logic         hit;
        r = '0;
        hit = 1'b0;
        bin64 = '0;
        used = (nbins_q == 0) ? 1 : (nbins_q > MAX_BINS_DEF) ? MAX_BINS_DEF : longint'(nbins_q);
        s = longint'($signed(raw_sample));
        if (op == MODE_ADD_VAL || op == MODE_READ_VAL) begin
            if (s > longint'(low_bound) && s < longint'(high_bound)) begin
                // exact Q32.32 product, integer part is the bin
                prod = 64'(s - longint'(low_bound)) * {32'd0, recip_q};
                bin64 = {32'd0, prod[63:32]};
                if (bin64 >= 64'(used))
                    bin64 = 64'(used - 1);
                hit = 1'b1;
            end
        end
        else if (op == MODE_ADD_IDX || op == MODE_READ_IDX || op == MODE_EDGE) begin
            bin64 = {54'd0, idx};
            hit = longint'(idx) < used;
        end
        case (op)
            MODE_ADD_VAL, MODE_ADD_IDX, MODE_READ_VAL, MODE_READ_IDX:
            begin
                if (hit)
                begin
                    if (op == MODE_ADD_VAL || op == MODE_ADD_IDX)
                    begin
                        bin_tally[bin64[9:0]] = bump(bin_tally[bin64[9:0]]);
                        sample_total = bump(sample_total);
                    end
                    r.count = bin_tally[bin64[9:0]];
                    r.in_range = 1'b1;
                    r.bin_number = bin64[9:0];
                end
            end
            MODE_TOTAL:
            begin
                r.in_range = 1'b1;
            end
            MODE_EDGE:
            begin
                edge_v = longint'(low_bound) + longint'(width_q) * longint'(idx);
                if (edge_v > EDGE_MAX)
                    edge_v = EDGE_MAX;
                if (edge_v < EDGE_MIN)
                    edge_v = EDGE_MIN;
                r.bin_edge = edge_v[31:0];
                r.in_range = hit;
                r.bin_number = idx;
            end
            default:
            begin
            end
        endcase
        r.total = sample_total;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hist_result_t got;
        hist_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BINS_DEF; i++)
                bin_tally[i] = '0;
            sample_total = '0;
            low_bound = RANGE_LOW_RST;
            high_bound = RANGE_HIGH_RST;
            width_q = BIN_WIDTH_RST;
            recip_q = INV_WIDTH_RST;
            nbins_q = NBINS_RST;
            expected_results.delete();
            error_tally = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.count = m_tdata[31:0];
                got.in_range = m_tuser;
                got.bin_number = m_tdata[41:32];
                got.bin_edge = m_tdata[73:42];
                got.total = m_tdata[105:74];
                if (expected_results.size() == 0)
                begin
                    error_tally++;
                    if (error_tally <= 10)
                        $display("unexpected result: count %h bin %0d total %0d",
                                 got.count, got.bin_number, got.total);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got != want)
                    begin
                        error_tally++;
                        if (error_tally <= 10)
                            $display({"mismatch (exp/act): count %h/%h in_range %b/%b ",
                                      "bin %0d/%0d edge %h/%h total %0d/%0d"},
                                     want.count, got.count, want.in_range, got.in_range,
                                     want.bin_number, got.bin_number, want.bin_edge,
                                     got.bin_edge, want.total, got.total);
                    end
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_addr))
                    REG_RANGE_LOW:  low_bound = cfg_wdata;
                    REG_RANGE_HIGH: high_bound = cfg_wdata;
                    REG_BIN_WIDTH:  width_q = cfg_wdata[30:0];
                    REG_INV_WIDTH:  recip_q = cfg_wdata;
                    REG_BIN_COUNT:  nbins_q = cfg_wdata[10:0];
                    default:
                    begin
                    end
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_histogram_op(s_tuser, s_tdata[31:0],
                                                                s_tdata[41:32]));
            mismatches <= error_tally;
            outstanding <= expected_results.size();
        end
    end

endmodule

/* bench/tb_uniform_bin_histogram_top.sv */
module tb_uniform_bin_histogram_top;
    import ubh_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS  = 550;
    localparam int RANDOM_PHASES = 5;
    localparam longint EDGE_LOW = 64'shFFFF_FFFF_8000_0000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [MODE_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    int                     mismatches;
    int                     outstanding;

    logic signed [31:0] cur_lo;
    logic signed [31:0] cur_hi;
    int                 cur_used;
    int                 burst_left = 0;
    int                 ready_left = 0;
    int                 ready_kind = 0;

    uniform_bin_histogram_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    histogram_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Receiver: switch between free flow, coin flips, heavy stall and slow toggling.
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_kind <= $urandom_range(0, 3);
            ready_left <= $urandom_range(8, 60);
        end
        else
            ready_left <= ready_left - 1;
        case (ready_kind)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            2:       m_tready <= ($urandom_range(0, 5) == 0);
            default: m_tready <= ready_left[2];
        endcase
    end

    task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr <= r;
        cfg_wdata <= v;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] lo, input logic [31:0] hi,
                              input logic [30:0] bw, input logic [31:0] ibw,
                              input logic [10:0] nb);
        write_reg(REG_RANGE_LOW, lo);
        write_reg(REG_RANGE_HIGH, hi);
        write_reg(REG_BIN_WIDTH, {1'b0, bw});
        write_reg(REG_INV_WIDTH, ibw);
        write_reg(REG_BIN_COUNT, {21'd0, nb});
        cfg_wr_en <= 1'b0;
        cur_lo = lo;
        cur_hi = hi;
        cur_used = (nb == 0) ? 1 : (nb > MAX_BINS_DEF) ? MAX_BINS_DEF : int'(nb);
    endtask

    task automatic send_item(input logic [2:0] op, input logic [31:0] smp,
                             input logic [9:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 10);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {6'd0, idx, smp};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Hold the sender idle until every result of the phase is back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial
    begin
        #4_000_000;
        $display("tb_uniform_bin_histogram_top: FAIL");
        $finish;
    end

    initial
    begin
        int          sent;
        int          pick;
        logic [2:0]  op;
        logic [31:0] smp;
        logic [9:0]  idx;
        logic [10:0] nb;
        longint      lo_l;
        longint      hi_l;
        longint      span;
        longint      bw_l;
        longint      ibw_l;
        logic [63:0] offs;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values, written explicitly: boundaries, first and last bins.
        set_config(RANGE_LOW_RST, RANGE_HIGH_RST, BIN_WIDTH_RST, INV_WIDTH_RST, NBINS_RST);
        send_item(MODE_ADD_VAL, 32'h0000_0000, 10'd0);
        send_item(MODE_ADD_VAL, 32'h0000_0001, 10'd0);
        send_item(MODE_ADD_VAL, 32'h03FF_FFFF, 10'd0);
        send_item(MODE_ADD_VAL, 32'h0400_0000, 10'd1023);
        send_item(MODE_ADD_VAL, 32'h8000_0000, 10'd0);
        send_item(MODE_ADD_VAL, 32'h0001_8000, 10'd0);
        send_item(MODE_ADD_IDX, 32'hFFFF_FFFF, 10'd0);
        send_item(MODE_ADD_IDX, 32'h0000_0000, 10'd1023);
        send_item(MODE_READ_VAL, 32'h0000_8000, 10'd0);
        send_item(MODE_READ_IDX, 32'h0000_0000, 10'd1023);
        send_item(MODE_TOTAL, 32'h0000_0000, 10'd0);
        send_item(MODE_EDGE, 32'h0000_0000, 10'd0);
        send_item(MODE_EDGE, 32'h0000_0000, 10'd1023);
        send_item(MODE_SPARE_LO, $urandom, 10'($urandom));
        send_item(MODE_SPARE_HI, $urandom, 10'($urandom));
        drain();

        // Four bins, wide bins: value past the end, index out of range, edge saturation.
        set_config(32'hFFFF_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h0001_0000, 11'd4);
        send_item(MODE_ADD_VAL, 32'h0010_0000, 10'd0);
        send_item(MODE_ADD_IDX, 32'h0000_0000, 10'd4);
        send_item(MODE_READ_IDX, 32'h0000_0000, 10'd1023);
        send_item(MODE_EDGE, 32'h0000_0000, 10'd1023);
        send_item(MODE_EDGE, 32'h0000_0000, 10'd0);
        drain();

        // Zero bins acts as one, zero reciprocal, full signed range.
        set_config(32'h8000_0000, 32'h7FFF_FFFF, 31'd1, 32'd0, 11'd0);
        send_item(MODE_ADD_VAL, 32'h7FFF_FFFE, 10'd0);
        send_item(MODE_ADD_IDX, 32'h0000_0000, 10'd1);
        send_item(MODE_READ_VAL, 32'h8000_0001, 10'd0);
        drain();

        // Empty range, bin count above the table size.
        set_config(32'h7FFF_FFFF, 32'h8000_0000, 31'h4000_0000, 32'hFFFF_FFFF, 11'd2047);
        send_item(MODE_ADD_VAL, 32'h0000_0000, 10'd0);
        send_item(MODE_READ_IDX, 32'h0000_0000, 10'd1023);
        send_item(MODE_EDGE, 32'h0000_0000, 10'd1023);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 7))
                0:       nb = 11'd0;
                1:       nb = 11'd2047;
                2:       nb = 11'd1024;
                3:       nb = 11'd1;
                4:       nb = 11'($urandom_range(0, 2047));
                default: nb = 11'($urandom_range(2, 64));
            endcase
            case ($urandom_range(0, 3))
                0:       lo_l = longint'($signed($urandom));
                1:       lo_l = -longint'($urandom_range(0, 32'h0100_0000));
                2:       lo_l = EDGE_LOW;
                default: lo_l = longint'($urandom_range(0, 32'h0010_0000));
            endcase
            case ($urandom_range(0, 5))
                0:       hi_l = 2147483647;
                1:       hi_l = lo_l - longint'($urandom_range(0, 100));
                default: hi_l = lo_l + longint'($urandom_range(64, 32'h0800_0000));
            endcase
            if (hi_l > 2147483647)
                hi_l = 2147483647;
            if (hi_l < EDGE_LOW)
                hi_l = EDGE_LOW;
            span = hi_l - lo_l;
            if (span > 0)
                bw_l = span / ((nb == 0) ? 1 : (nb > MAX_BINS_DEF) ? MAX_BINS_DEF : longint'(nb));
            else
                bw_l = longint'($urandom_range(1, 32'h7FFF_FFFF));
            if (bw_l < 1)
                bw_l = 1;
            if (bw_l > 64'h7FFF_FFFF)
                bw_l = 64'h7FFF_FFFF;
            case ($urandom_range(0, 7))
                0:       ibw_l = 0;
                1:       ibw_l = 64'hFFFF_FFFF;
                2:       ibw_l = longint'($urandom);
                default: ibw_l = (64'sd1 <<< 32) / bw_l;
            endcase
            if (ibw_l > 64'hFFFF_FFFF)
                ibw_l = 64'hFFFF_FFFF;
            set_config(32'(lo_l), 32'(hi_l), 31'(bw_l), 32'(ibw_l), nb);

            sent = 0;
            while (sent < RANDOM_ITEMS / RANDOM_PHASES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    op = MODE_ADD_VAL;
                else if (pick < 45)
                    op = MODE_ADD_IDX;
                else if (pick < 60)
                    op = MODE_READ_VAL;
                else if (pick < 75)
                    op = MODE_READ_IDX;
                else if (pick < 82)
                    op = MODE_TOTAL;
                else if (pick < 96)
                    op = MODE_EDGE;
                else
                    op = ($urandom_range(0, 1) != 0) ? MODE_SPARE_HI : MODE_SPARE_LO;

                // Mostly values strictly inside the range, some on or just inside its bounds, some anywhere.
                span = longint'(cur_hi) - longint'(cur_lo);
                pick = $urandom_range(0, 9);
                if (pick < 8 && span >= 2)
                begin
                    offs = {$urandom, $urandom} % 64'(span - 1);
                    smp = 32'(longint'(cur_lo) + 1 + longint'(offs));
                end
                else if (pick == 8)
                begin
                    case ($urandom_range(0, 3))
                        0:       smp = cur_lo;
                        1:       smp = cur_lo + 32'sd1;
                        2:       smp = cur_hi - 32'sd1;
                        default: smp = cur_hi;
                    endcase
                end
                else
                    smp = $urandom;

                if ($urandom_range(0, 99) < 85)
                    idx = 10'($urandom_range(0, cur_used - 1));
                else
                    idx = 10'($urandom);

                send_item(op, smp, idx);
                if (op != MODE_SPARE_LO && op != MODE_SPARE_HI)
                    sent++;
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_uniform_bin_histogram_top: PASS");
        else
            $display("tb_uniform_bin_histogram_top: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/ubh_pkg.sv
hdl/ubh_ctrl.sv
hdl/ubh_datapath.sv
hdl/uniform_bin_histogram_top.sv
bench/histogram_checker.sv
bench/tb_uniform_bin_histogram_top.sv
